// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the priority queue unit.
// No dependencies; each file that checks itself includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is low.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Property checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/stpq_pkg.sv =====
// Types, codes and sizes for the stable two-level priority queue.
// No dependencies; used by the interfaces, the cell and the top level.
`timescale 1ns / 1ps

package stpq_pkg;

    localparam int unsigned QUEUE_DEPTH = 16;
    localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // request kinds
    typedef enum logic [1:0] {
        FUNC_ENQ = 2'd0,
        FUNC_DEQ = 2'd1,
        FUNC_REM = 2'd2,
        FUNC_NOP = 2'd3
    } t_func;

    // result codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // one queued entry
    typedef struct packed {
        logic [15:0] id;
        logic [6:0]  age;
        logic        urgent;
    } t_entry;

    // request beat
    typedef struct packed {
        t_func       func;
        logic [15:0] entry_id;
        logic [6:0]  entry_age;
        logic        entry_urgent;
    } t_req;

    // response beat
    typedef struct packed {
        t_status          status;
        logic [15:0]      out_id;
        logic [6:0]       out_age;
        logic             out_urgent;
        logic [CNT_W-1:0] waiting_count;
    } t_rsp;

    // command broadcast to every cell
    typedef struct packed {
        logic   enq_en;  // insert the new entry this cycle
        logic   rem_en;  // take out the first matching entry this cycle
        logic   deq;     // every valid cell matches (pop head)
        t_entry entry;   // new entry, or key id for remove
    } t_cell_cmd;

    // data handed from a cell to its right-hand neighbor
    typedef struct packed {
        t_entry entry;   // stored entry, shifted right on insert
        logic   ins;     // this cell is at or behind the insert point
        logic   hit;     // a match was found at or before this cell
    } t_link;

endpackage

// ===== rtl/core/stpq_req_if.sv =====
// Request channel of the priority queue: valid/ready with a request beat.
// Depends on stpq_pkg.
`timescale 1ns / 1ps

interface stpq_req_if;
    logic            valid;
    logic            ready;
    stpq_pkg::t_req  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/stpq_rsp_if.sv =====
// Response channel of the priority queue: valid/ready with a response beat.
// Depends on stpq_pkg.
`timescale 1ns / 1ps

interface stpq_rsp_if;
    logic            valid;
    logic            ready;
    stpq_pkg::t_rsp  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/stpq_cell.sv =====
// One slot of the queue: holds an entry, compares it against the broadcast
// command and shifts with its neighbors. Depends on stpq_pkg.
`timescale 1ns / 1ps

module stpq_cell (
    input  logic                i_clk,
    input  stpq_pkg::t_cell_cmd i_cmd,
    input  logic                i_valid,      // slot below the fill count
    input  logic                i_tail,       // first free slot
    input  stpq_pkg::t_link     i_left,
    input  stpq_pkg::t_entry    i_right,
    output stpq_pkg::t_link     o_link,
    output stpq_pkg::t_entry    o_entry,
    output stpq_pkg::t_entry    o_hit_entry,
    output logic                o_first
);

    stpq_pkg::t_entry r_entry, n_entry;
    logic             w_match;
    logic             w_ins;

    // remove matches on id, dequeue matches any valid slot
    assign w_match = i_valid && (i_cmd.deq || (r_entry.id == i_cmd.entry.id));

    // insert point: first normal slot for an urgent entry, else the tail
    assign w_ins = i_valid ? (i_cmd.entry.urgent && !r_entry.urgent) : i_tail;

    // next slot content
    always_comb begin
        n_entry = r_entry;
        priority if (i_cmd.enq_en) begin
            if (i_left.ins) begin
                n_entry = i_left.entry;
            end else if (w_ins) begin
                n_entry = i_cmd.entry;
            end
        end else if (i_cmd.rem_en && (i_left.hit || w_match)) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    // hand-off to the neighbors
    assign o_first     = w_match && !i_left.hit;
    assign o_hit_entry = o_first ? r_entry : '0;
    assign o_entry     = r_entry;
    assign o_link      = '{entry: r_entry, ins: w_ins, hit: i_left.hit || w_match};

endmodule

// ===== rtl/core/stable_two_level_priority_queue_unit.sv =====
// Top level of the stable two-level priority queue: a row of stpq_cell
// slots, the fill count and the registered response. Depends on stpq_pkg,
// stpq_req_if, stpq_rsp_if, stpq_cell and assert_macros.svh.
//
// Usage:
//   i_req carries one request per beat: enqueue, dequeue head or remove by
//   id. o_rsp returns exactly one beat per request, in request order, with
//   the status, the affected entry and the count left waiting.
//   Urgent entries leave before normal ones; within a level, first in is
//   first out. A full queue rejects an enqueue with a full status.
//   The response is registered and shows in the cycle after acceptance.
//   Throughput: one request per cycle while responses are taken. Every slot
//   compares and shifts in the same cycle; the id match and insert point
//   ripple along the row of cells.
//   When the receiver stalls, the response waits in the output register
//   and i_req.ready drops until it is taken; a request is still taken in
//   the same cycle the waiting response leaves.
//   Reset (i_rst_n low, synchronous) empties the queue and drops the
//   response valid. Slot contents are not cleared; the fill count alone
//   marks which slots hold entries.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stable_two_level_priority_queue_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    stpq_req_if.sink          i_req,
    stpq_rsp_if.source        o_rsp
);

    localparam int unsigned DEPTH = stpq_pkg::QUEUE_DEPTH;
    localparam int unsigned CNT_W = stpq_pkg::CNT_W;

    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_rsp_valid;
    stpq_pkg::t_rsp      r_rsp, n_rsp;

    logic                w_acc;
    logic                w_full;
    logic                w_found;
    stpq_pkg::t_req      w_req;
    stpq_pkg::t_entry    w_new;
    stpq_pkg::t_cell_cmd w_cmd;
    stpq_pkg::t_entry    w_hit;

    stpq_pkg::t_link     w_link  [DEPTH+1];
    stpq_pkg::t_entry    w_entry [DEPTH];
    stpq_pkg::t_entry    w_hit_e [DEPTH];
    logic [DEPTH-1:0]    w_first;

    // handshake: take a request whenever the output register is free
    assign w_acc       = i_req.valid && i_req.ready;
    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.payload = r_rsp;

    assign w_req  = i_req.payload;
    assign w_full = (r_count == CNT_W'(DEPTH));
    assign w_new  = '{id: w_req.entry_id, age: w_req.entry_age,
                      urgent: w_req.entry_urgent};

    // command broadcast to the cells
    always_comb begin
        w_cmd.enq_en = w_acc && (w_req.func == stpq_pkg::FUNC_ENQ) && !w_full;
        w_cmd.rem_en = w_acc && ((w_req.func == stpq_pkg::FUNC_DEQ) ||
                                 (w_req.func == stpq_pkg::FUNC_REM));
        w_cmd.deq    = (w_req.func == stpq_pkg::FUNC_DEQ);
        w_cmd.entry  = w_new;
    end

    // row of slots; slot 0 is the head
    assign w_link[0] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        stpq_pkg::t_entry w_right;
        if (g + 1 < DEPTH) begin : g_mid
            assign w_right = w_entry[g+1];
        end else begin : g_end
            assign w_right = '0;
        end

        stpq_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_valid     (CNT_W'(g) < r_count),
            .i_tail      (CNT_W'(g) == r_count),
            .i_left      (w_link[g]),
            .i_right     (w_right),
            .o_link      (w_link[g+1]),
            .o_entry     (w_entry[g]),
            .o_hit_entry (w_hit_e[g]),
            .o_first     (w_first[g])
        );
    end

    assign w_found = w_link[DEPTH].hit;

    // only the first matching slot drives a nonzero entry
    always_comb begin
        w_hit = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_hit = w_hit | w_hit_e[i];
        end
    end

    // fill count
    always_comb begin
        n_count = r_count;
        priority if (w_cmd.enq_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_cmd.rem_en && w_found) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // response beat
    always_comb begin
        n_rsp = '0;
        n_rsp.waiting_count = n_count;
        unique case (w_req.func)
            stpq_pkg::FUNC_ENQ: begin
                if (w_full) begin
                    n_rsp.status = stpq_pkg::ST_FULL;
                end else begin
                    n_rsp.status     = stpq_pkg::ST_OK;
                    n_rsp.out_id     = w_new.id;
                    n_rsp.out_age    = w_new.age;
                    n_rsp.out_urgent = w_new.urgent;
                end
            end
            stpq_pkg::FUNC_DEQ, stpq_pkg::FUNC_REM: begin
                if (w_found) begin
                    n_rsp.status     = stpq_pkg::ST_OK;
                    n_rsp.out_id     = w_hit.id;
                    n_rsp.out_age    = w_hit.age;
                    n_rsp.out_urgent = w_hit.urgent;
                end else if (w_req.func == stpq_pkg::FUNC_DEQ) begin
                    n_rsp.status = stpq_pkg::ST_EMPTY;
                end else begin
                    n_rsp.status = stpq_pkg::ST_NOT_FOUND;
                end
            end
            default: begin
                n_rsp.status = stpq_pkg::ST_OK;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_acc) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // response payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_rsp <= n_rsp;
        end
    end

    // checks
    `ASSERT_RST(a_count_bound, i_clk, i_rst_n,
        r_count <= CNT_W'(DEPTH), "fill count above queue depth")
    `ASSERT_RST(a_single_hit, i_clk, i_rst_n,
        $onehot0(w_first), "more than one slot claims the first match")
    `ASSERT_RST(a_enq_grows, i_clk, i_rst_n,
        w_cmd.enq_en |=> (r_count == $past(r_count) + CNT_W'(1)),
        "accepted enqueue did not grow the queue")
    `ASSERT_RST(a_full_status, i_clk, i_rst_n,
        (o_rsp.valid && (r_rsp.status == stpq_pkg::ST_FULL)) |->
            (r_rsp.waiting_count == CNT_W'(DEPTH)),
        "full status reported below depth")

endmodule

// ===== bench/stpq_checker.sv =====
// Checker for the stable two-level priority queue: watches both channels,
// predicts every response and compares it field by field.
// Depends on stpq_pkg, stpq_req_if and stpq_rsp_if.
`timescale 1ns / 1ps

module stpq_checker
    import stpq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    stpq_req_if         i_req,
    stpq_rsp_if         i_rsp,
    output int unsigned o_mismatches,
    output int unsigned o_outstanding
);

    // predicted queue contents, service order from slot 0
    t_entry      line_slots [QUEUE_DEPTH];
    int unsigned line_count;

    // responses owed by the block, oldest first
    t_rsp        owed_rsp [$];
    int unsigned mismatch_cnt;
    int unsigned owed_cnt;

    assign o_mismatches  = mismatch_cnt;
    assign o_outstanding = owed_cnt;

    initial begin
        mismatch_cnt = 0;
        owed_cnt     = 0;
        line_count   = 0;
    end

    // take out one slot and close the gap behind it
    function automatic t_entry pull_slot(input int unsigned pos);
        t_entry      taken;
        int unsigned i;
        taken = line_slots[pos];
        for (i = pos; i + 1 < line_count; i++) begin
            line_slots[i] = line_slots[i + 1];
        end
        line_count--;
        return taken;
    endfunction

    // apply one request to the predicted queue, return its response
    function automatic t_rsp serve_request(input t_req r);
        t_rsp        res;
        t_entry      hit;
        int unsigned pos;
        int unsigned i;
        bit          found;
        res        = '0;
        res.status = ST_OK;
        found      = 1'b0;
        case (r.func)
            FUNC_ENQ: begin
                if (line_count >= QUEUE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    // goes behind every entry of the same or a higher level
                    pos = 0;
                    while (pos < line_count && (!r.entry_urgent || line_slots[pos].urgent))
                        pos++;
                    for (i = line_count; i > pos; i--) begin
                        line_slots[i] = line_slots[i - 1];
                    end
                    line_slots[pos].id     = r.entry_id;
                    line_slots[pos].age    = r.entry_age;
                    line_slots[pos].urgent = r.entry_urgent;
                    line_count++;
                    res.out_id     = r.entry_id;
                    res.out_age    = r.entry_age;
                    res.out_urgent = r.entry_urgent;
                end
            end
            FUNC_DEQ: begin
                if (line_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    hit            = pull_slot(0);
                    res.out_id     = hit.id;
                    res.out_age    = hit.age;
                    res.out_urgent = hit.urgent;
                end
            end
            FUNC_REM: begin
                // match nearest the head wins
                for (i = 0; i < line_count && !found; i++) begin
                    if (line_slots[i].id == r.entry_id) begin
                        found          = 1'b1;
                        hit            = pull_slot(i);
                        res.out_id     = hit.id;
                        res.out_age    = hit.age;
                        res.out_urgent = hit.urgent;
                    end
                end
                if (!found)
                    res.status = ST_NOT_FOUND;
            end
            default: begin
                // unused code: no operation
            end
        endcase
        res.waiting_count = CNT_W'(line_count);
        return res;
    endfunction

    task automatic flag_field(input string fname, input logic [15:0] want,
                              input logic [15:0] got);
        if (got !== want) begin
            mismatch_cnt++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, fname, want, got);
        end
    endtask

    // response beats are compared before this edge's request is predicted
    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            owed_rsp.delete();
            line_count = 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (owed_rsp.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: response beat with none expected, got 0x%0h",
                             $time, i_rsp.payload);
                end else begin
                    want = owed_rsp.pop_front();
                    flag_field("status", 16'(want.status), 16'(i_rsp.payload.status));
                    flag_field("out_id", want.out_id, i_rsp.payload.out_id);
                    flag_field("out_age", 16'(want.out_age), 16'(i_rsp.payload.out_age));
                    flag_field("out_urgent", 16'(want.out_urgent),
                               16'(i_rsp.payload.out_urgent));
                    flag_field("waiting_count", 16'(want.waiting_count),
                               16'(i_rsp.payload.waiting_count));
                end
            end
            if (i_req.valid && i_req.ready)
                owed_rsp.push_back(serve_request(i_req.payload));
        end
        owed_cnt = owed_rsp.size();
    end

endmodule

// ===== bench/tb_stable_two_level_priority_queue_unit.sv =====
// Testbench top for the stable two-level priority queue unit: drives requests
// and response stalls, gives the verdict. Depends on stpq_pkg, the channel
// interfaces, stpq_checker and the unit itself.
`timescale 1ns / 1ps

module tb_stable_two_level_priority_queue_unit;
    import stpq_pkg::*;

    localparam int unsigned PHASE_BEATS = 617;
    localparam int unsigned DRAIN_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    logic [15:0] recent_ids [8];

    stpq_req_if req_if ();
    stpq_rsp_if rsp_if ();

    stable_two_level_priority_queue_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    stpq_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_if),
        .i_rsp         (rsp_if),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver stalls
    always @(negedge i_clk) begin
        rsp_if.ready = ($urandom_range(99) >= snk_idle_pct);
    end

    // hard stop
    initial begin
        #2ms;
        $display("== FAIL ==");
        $finish;
    end

    // one request beat; called and returns at a falling edge, valid left high
    task automatic send_req(input t_req r);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid   = 1'b1;
        req_if.payload = r;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
    endtask

    // hold off until every owed response has come back or the drain limit runs out
    task automatic wait_drained();
        int unsigned n;
        n = 0;
        req_if.valid = 1'b0;
        do begin
            @(negedge i_clk);
            n++;
        end while (outstanding != 0 && n < DRAIN_LIMIT);
    endtask

    function automatic t_req make_req(input t_func f, input logic [15:0] id,
                                      input logic [6:0] age, input logic urg);
        t_req r;
        r.func         = f;
        r.entry_id     = id;
        r.entry_age    = age;
        r.entry_urgent = urg;
        return r;
    endfunction

    // random request; ids come often from a small pool so removes hit
    function automatic t_req pick_request(input int unsigned enq_pct);
        t_req        r;
        int unsigned roll;
        roll           = $urandom_range(99);
        r.entry_id     = 16'($urandom_range(65535));
        r.entry_age    = 7'($urandom_range(127));
        r.entry_urgent = 1'($urandom_range(1));
        if (roll < 3) begin
            r.func = FUNC_NOP;
        end else if (roll < 3 + enq_pct * 97 / 100) begin
            r.func = FUNC_ENQ;
            if ($urandom_range(1))
                r.entry_id = recent_ids[$urandom_range(7)];
            recent_ids[$urandom_range(7)] = r.entry_id;
        end else if ($urandom_range(1)) begin
            r.func = FUNC_DEQ;
        end else begin
            r.func = FUNC_REM;
            if ($urandom_range(3) != 0)
                r.entry_id = recent_ids[$urandom_range(7)];
        end
        return r;
    endfunction

    // empty-queue cases, a full fill with duplicate ids, rejection, removes
    task automatic directed_part();
        int unsigned i;
        logic [15:0] id;
        logic [6:0]  age;
        send_req(make_req(FUNC_DEQ, 16'h0000, 7'd0, 1'b0));
        send_req(make_req(FUNC_REM, 16'hFFFF, 7'd127, 1'b1));
        send_req(make_req(FUNC_NOP, 16'hFFFF, 7'd127, 1'b1));
        for (i = 0; i < QUEUE_DEPTH; i++) begin
            if (i == 0)
                id = 16'h0000;
            else if (i == QUEUE_DEPTH - 1)
                id = 16'hFFFF;
            else if (i % 4 == 1)
                id = 16'h1234;
            else
                id = 16'h5A00 + 16'(i);
            age = (i == 0) ? 7'd0 : (i == QUEUE_DEPTH - 1) ? 7'd127 : 7'(i * 7);
            send_req(make_req(FUNC_ENQ, id, age, i[0] ^ i[1]));
        end
        send_req(make_req(FUNC_ENQ, 16'hFFFF, 7'd127, 1'b1));
        send_req(make_req(FUNC_REM, 16'h1234, 7'd0, 1'b0));
        send_req(make_req(FUNC_REM, 16'hBEEF, 7'd0, 1'b0));
        send_req(make_req(FUNC_DEQ, 16'h0000, 7'd0, 1'b0));
        send_req(make_req(FUNC_DEQ, 16'h0000, 7'd0, 1'b0));
    endtask

    initial begin
        int unsigned phase;
        int unsigned n;
        int unsigned enq_pct;
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        src_idle_pct   = 0;
        snk_idle_pct   = 0;
        enq_pct        = 50;
        for (n = 0; n < 8; n++) begin
            recent_ids[n] = 16'($urandom_range(65535));
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        directed_part();
        wait_drained();

        // idle mixes: receiver-heavy stalls, sender-heavy stalls, none
        for (phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 53 : 0;
            snk_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 32 : 0;
            for (n = 0; n < PHASE_BEATS; n++) begin
                // shift the fill bias so the queue swings between empty and full
                if (n % 64 == 0)
                    enq_pct = 30 + 20 * $urandom_range(2);
                send_req(pick_request(enq_pct));
            end
            wait_drained();
        end

        repeat (10) @(negedge i_clk);
        if (outstanding != 0)
            $display("%0t: %0d responses never arrived", $time, outstanding);
        if (mismatches == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/stpq_pkg.sv
rtl/core/stpq_req_if.sv
rtl/core/stpq_rsp_if.sv
rtl/core/stpq_cell.sv
rtl/core/stable_two_level_priority_queue_unit.sv
bench/stpq_checker.sv
bench/tb_stable_two_level_priority_queue_unit.sv
